>>> sv/rld_pkg.sv
// Shared types and constants for the run list decoder.
package rld_pkg;

  // Largest length or offset field, in bytes
  localparam int MAX_FIELD_BYTES = 8;

  // Result status codes
  localparam logic [2:0] ST_RUN       = 3'd0;
  localparam logic [2:0] ST_END       = 3'd1;
  localparam logic [2:0] ST_BAD_HDR   = 3'd2;
  localparam logic [2:0] ST_NEG_LEN   = 3'd3;
  localparam logic [2:0] ST_NEG_LCN   = 3'd4;
  localparam logic [2:0] ST_VCN_BOUND = 3'd5;

  // Parsed run or end event handed from the parser to the run unit
  typedef struct packed {
    logic        new_list;  // a list start came since the previous job
    logic [2:0]  kind;      // ST_RUN or an end status
    logic [63:0] len;       // cluster count
    logic [63:0] len_m1;    // cluster count minus one
    logic [63:0] off;       // sign-extended offset
    logic        sparse;    // offset was zero
  } job_t;

  // One result beat
  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] vcn_first;
    logic [62:0] run_clusters;
    logic [62:0] run_lcn;
    logic        sparse;
  } result_t;

endpackage

>>> sv/rld_fifo.sv
// Small register-based FIFO used between the parser, run unit and output.
module rld_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("fifo occupancy above depth");

endmodule

>>> sv/rld_front.sv
// Byte parser: header decode, field accumulation and job forming.
module rld_front import rld_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_valid,
  input  logic [7:0] data_byte,
  input  logic       list_start,
  output logic       job_push,
  output job_t       job
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_LENGTH = 2'd1;
  localparam logic [1:0] PH_OFFSET = 2'd2;
  localparam logic [1:0] PH_STOP   = 2'd3;

  logic [1:0]  phase_r, phase_nxt, eff_phase;
  logic [3:0]  lsz_r, lsz_nxt;
  logic [3:0]  osz_r, osz_nxt;
  logic [3:0]  cnt_r, cnt_nxt, cnt_inc;
  logic [63:0] len_r, len_nxt, len_new;
  logic [63:0] off_r, off_nxt, off_new;
  logic        pend_r, pend_nxt;
  logic [63:0] byte_sh;
  logic [63:0] ext_mask;
  logic [5:0]  sign_idx;
  logic [2:0]  osz_m1;
  logic [63:0] off_ext;

  // Byte placed at its little-endian position
  assign byte_sh = 64'(data_byte) << {cnt_r[2:0], 3'b000};
  assign len_new = len_r | byte_sh;
  assign off_new = off_r | byte_sh;
  assign cnt_inc = cnt_r + 4'd1;

  // Sign extension of a short offset field
  assign osz_m1   = osz_r[2:0] - 3'd1;
  assign sign_idx = {osz_m1, 3'b111};
  assign ext_mask = ~64'd0 << {osz_r, 3'b000};
  assign off_ext  = off_new[sign_idx] ? (off_new | ext_mask) : off_new;

  assign eff_phase = list_start ? PH_HEADER : phase_r;

  // Parser next state and job forming
  always_comb begin
    phase_nxt    = phase_r;
    lsz_nxt      = lsz_r;
    osz_nxt      = osz_r;
    cnt_nxt      = cnt_r;
    len_nxt      = len_r;
    off_nxt      = off_r;
    pend_nxt     = pend_r;
    job_push     = 1'b0;
    job.new_list = pend_r | list_start;
    job.kind     = ST_RUN;
    job.len      = '0;
    job.off      = '0;
    job.sparse   = 1'b1;
    if (byte_valid) begin
      if (list_start) begin
        pend_nxt = 1'b1;
      end
      case (eff_phase)
        PH_HEADER: begin
          lsz_nxt = data_byte[3:0];
          osz_nxt = data_byte[7:4];
          len_nxt = '0;
          off_nxt = '0;
          cnt_nxt = '0;
          if (data_byte == 8'd0) begin
            job_push  = 1'b1;
            job.kind  = ST_END;
            phase_nxt = PH_STOP;
          end else if (data_byte[3:0] > 4'(MAX_FIELD_BYTES) ||
                       data_byte[7:4] > 4'(MAX_FIELD_BYTES)) begin
            job_push  = 1'b1;
            job.kind  = ST_BAD_HDR;
            phase_nxt = PH_STOP;
          end else if (data_byte[3:0] != 4'd0) begin
            phase_nxt = PH_LENGTH;
          end else if (data_byte[7:4] == 4'd0) begin
            // empty length and offset: zero-length sparse run
            job_push  = 1'b1;
            phase_nxt = PH_HEADER;
          end else begin
            phase_nxt = PH_OFFSET;
          end
        end
        PH_LENGTH: begin
          len_nxt = len_new;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= lsz_r) begin
            if (len_new[63]) begin
              job_push  = 1'b1;
              job.kind  = ST_NEG_LEN;
              phase_nxt = PH_STOP;
            end else if (osz_r == 4'd0) begin
              job_push  = 1'b1;
              job.len   = len_new;
              phase_nxt = PH_HEADER;
            end else begin
              cnt_nxt   = '0;
              phase_nxt = PH_OFFSET;
            end
          end
        end
        PH_OFFSET: begin
          off_nxt = off_new;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= osz_r) begin
            job_push   = 1'b1;
            job.len    = len_r;
            job.off    = off_ext;
            job.sparse = (off_new == 64'd0);
            phase_nxt  = PH_HEADER;
          end
        end
        default: begin
          phase_nxt = PH_STOP;
        end
      endcase
      if (job_push) begin
        pend_nxt = 1'b0;
      end
    end
    job.len_m1 = job.len - 64'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pend_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Field registers, no reset
  always_ff @(posedge clk) begin
    lsz_r <= lsz_nxt;
    osz_r <= osz_nxt;
    cnt_r <= cnt_nxt;
    len_r <= len_nxt;
    off_r <= off_nxt;
  end

  a_push_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> byte_valid)
    else $error("job formed without an input beat");

  a_stop_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_STOP) && !(byte_valid && list_start) |=> phase_r == PH_STOP)
    else $error("parser left stop without a list start");

endmodule

>>> sv/rld_back.sv
// Run unit: running cluster sums, bound check and result forming.
module rld_back import rld_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  input  logic        job_valid,
  input  job_t        job,
  output logic        job_pop,
  input  logic        res_full,
  output logic        res_push,
  output result_t     res
);

  logic [63:0] limit_r;
  logic [63:0] lcn_r, lcn_nxt, lcn_base, lcn_sum;
  logic [63:0] vcn_r, vcn_nxt, vcn_base, vcn_end, vcn_last;
  logic        stop_r, stop_nxt, stop_eff;

  assign job_pop  = job_valid && !res_full;
  assign lcn_base = job.new_list ? 64'd0 : lcn_r;
  assign vcn_base = job.new_list ? 64'd0 : vcn_r;
  assign stop_eff = job.new_list ? 1'b0 : stop_r;
  assign lcn_sum  = lcn_base + job.off;
  assign vcn_end  = vcn_base + job.len;
  assign vcn_last = vcn_base + job.len_m1;

  // Result forming and running state update
  always_comb begin
    lcn_nxt  = lcn_r;
    vcn_nxt  = vcn_r;
    stop_nxt = stop_r;
    res_push = 1'b0;
    res      = '0;
    if (job_pop && !stop_eff) begin
      res_push = 1'b1;
      lcn_nxt  = lcn_base;
      vcn_nxt  = vcn_base;
      stop_nxt = 1'b0;
      if (job.kind != ST_RUN) begin
        res.status = job.kind;
        stop_nxt   = 1'b1;
      end else if (lcn_sum[63]) begin
        res.status = ST_NEG_LCN;
        stop_nxt   = 1'b1;
      end else if (vcn_last > limit_r) begin
        res.status = ST_VCN_BOUND;
        stop_nxt   = 1'b1;
      end else begin
        res.status       = ST_RUN;
        res.vcn_first    = vcn_base;
        res.run_clusters = job.len[62:0];
        res.run_lcn      = job.sparse ? 63'd0 : lcn_sum[62:0];
        res.sparse       = job.sparse;
        lcn_nxt          = lcn_sum;
        vcn_nxt          = vcn_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
      lcn_r   <= '0;
      vcn_r   <= '0;
      stop_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      lcn_r  <= lcn_nxt;
      vcn_r  <= vcn_nxt;
      stop_r <= stop_nxt;
    end
  end

  a_res_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> job_pop)
    else $error("result without a job");

  a_err_stops: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && (res.status == ST_NEG_LCN || res.status == ST_VCN_BOUND)
    |=> stop_r)
    else $error("error result did not stop the list");

endmodule

>>> sv/run_list_decoder_unit.sv
// Run list decoder top level: parser, job queue, run unit, result queue.
// A byte's job is registered in the job queue, its result in the result queue.
// Throughput: a byte per cycle unless in_full; a job per cycle unless res_full.
// in_full follows the job queue; out_empty follows the result queue.
// Reset (rst_n low, synchronous): parser to header, running sums and limit to 0.
// Both queues empty after reset; no clearing pass.
module run_list_decoder_unit import rld_pkg::*; #(
  parameter int JOB_DEPTH = 2,
  parameter int RES_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_list_start,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_status,
  output logic [63:0] out_start_vcn,
  output logic [62:0] out_run_clusters,
  output logic [62:0] out_run_lcn,
  output logic        out_sparse,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata
);

  logic    in_beat;
  logic    job_push, job_pop, job_empty;
  job_t    job_in, job_out;
  logic    res_push, res_full;
  result_t res_in, res_out;

  assign in_beat = in_push && !in_full;

  // Front: byte parser
  rld_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_beat),
    .data_byte  (in_data_byte),
    .list_start (in_list_start),
    .job_push   (job_push),
    .job        (job_in)
  );

  // Job queue between parser and run unit
  rld_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_in),
    .full  (in_full),
    .pop   (job_pop),
    .rdata (job_out),
    .empty (job_empty)
  );

  // Back: run unit
  rld_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .job_valid (!job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // Result queue
  rld_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_out),
    .empty (out_empty)
  );

  assign out_status       = res_out.status;
  assign out_start_vcn    = res_out.vcn_first;
  assign out_run_clusters = res_out.run_clusters;
  assign out_run_lcn      = res_out.run_lcn;
  assign out_sparse       = res_out.sparse;

endmodule
